// ===== rtl/trend_breakout_signal_assert.svh =====
// Assertion macros used by the trend breakout signal top level.
`ifndef TREND_BREAKOUT_SIGNAL_ASSERT_SVH
`define TREND_BREAKOUT_SIGNAL_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk and disabled in reset.
`define TBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, checked on clk and disabled in reset.
`define TBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TBS_ASSERT_IMP(lbl, ante, cons)
`define TBS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/tbs_pkg.sv =====
// Package with constants, types and helper functions of the trend breakout signal.
package tbs_pkg;

  localparam int HISTORY_DEPTH = 256;
  localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int PRICE_BITS    = 40;
  localparam int TIME_BITS     = 63;
  localparam int SUM_BITS      = 48;
  localparam int WIDE_BITS     = 80;
  localparam int MULB_BITS     = 22;
  localparam int STEP_BITS     = 7;
  localparam int MUL_STEPS     = MULB_BITS;
  localparam int DIV_STEPS     = WIDE_BITS;
  localparam int SINCE_BITS    = 21;

  localparam logic [SINCE_BITS-1:0] SINCE_MAX   = {SINCE_BITS{1'b1}};
  localparam logic [SINCE_BITS-1:0] SINCE_RESET = SINCE_BITS'(1 << 20);
  localparam logic [PRICE_BITS-1:0] PRICE_MAX   = {PRICE_BITS{1'b1}};

  // Signal codes.
  localparam logic [1:0] SIG_NONE  = 2'd0;
  localparam logic [1:0] SIG_LONG  = 2'd1;
  localparam logic [1:0] SIG_SHORT = 2'd2;

  // Register indexes.
  localparam logic [2:0] REG_FAST     = 3'd0;
  localparam logic [2:0] REG_SLOW     = 3'd1;
  localparam logic [2:0] REG_BREAKOUT = 3'd2;
  localparam logic [2:0] REG_RANGE    = 3'd3;
  localparam logic [2:0] REG_STOP     = 3'd4;
  localparam logic [2:0] REG_REWARD   = 3'd5;
  localparam logic [2:0] REG_MINVOL   = 3'd6;
  localparam logic [2:0] REG_COOL     = 3'd7;

  typedef enum logic {OP_MUL, OP_DIV} arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic done;
    logic rem_nz;
  } arith_rsp_t;

  // Limit a quotient to 2^PRICE_BITS; anything larger acts the same on a price.
  function automatic logic [PRICE_BITS+1:0] clamp_q(input logic [WIDE_BITS-1:0] q);
    logic [PRICE_BITS+1:0] lim;
    lim = (PRICE_BITS+2)'(1) << PRICE_BITS;
    if (q >= WIDE_BITS'(lim)) return lim;
    return q[PRICE_BITS+1:0];
  endfunction

  // Mark plus distance, saturated at the top and raised to at least 1.
  function automatic logic [PRICE_BITS-1:0] add_sat(input logic [PRICE_BITS-1:0] m,
                                                    input logic [PRICE_BITS+1:0] d);
    logic [PRICE_BITS+1:0] s;
    s = {2'b00, m} + d;
    if (s > {2'b00, PRICE_MAX}) return PRICE_MAX;
    if (s == '0) return PRICE_BITS'(1);
    return s[PRICE_BITS-1:0];
  endfunction

  // Mark minus distance, floored at 1.
  function automatic logic [PRICE_BITS-1:0] sub_floor1(input logic [PRICE_BITS-1:0] m,
                                                       input logic [PRICE_BITS+1:0] d);
    if (d >= {2'b00, m}) return PRICE_BITS'(1);
    return m - d[PRICE_BITS-1:0];
  endfunction

endpackage

// ===== rtl/tbs_arith.sv =====
// Shared bit-serial multiplier and restoring divider of the trend breakout signal.
module tbs_arith (
  input  logic                           clk,
  input  logic                           rst,
  input  tbs_pkg::arith_req_t            req,
  input  logic [tbs_pkg::WIDE_BITS-1:0]  opa,
  input  logic [tbs_pkg::MULB_BITS-1:0]  opb,
  output tbs_pkg::arith_rsp_t            rsp,
  output logic [tbs_pkg::WIDE_BITS-1:0]  result
);
  import tbs_pkg::*;

  logic                 busy;
  logic                 done;
  arith_op_t            op;
  logic [STEP_BITS-1:0] cnt;
  logic [WIDE_BITS-1:0] acc;
  logic [WIDE_BITS-1:0] work;
  logic [MULB_BITS-1:0] opb_r;
  logic [MULB_BITS-1:0] rem;
  logic [MULB_BITS:0]   trial;
  logic [MULB_BITS:0]   diff;

  // Partial remainder with the next dividend bit shifted in.
  assign trial = {rem, work[WIDE_BITS-1]};
  assign diff  = trial - {1'b0, opb_r};

  // One multiply or divide step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        op    <= req.op;
        work  <= opa;
        opb_r <= opb;
        acc   <= '0;
        rem   <= '0;
        cnt   <= (req.op == OP_MUL) ? STEP_BITS'(MUL_STEPS - 1) : STEP_BITS'(DIV_STEPS - 1);
      end else if (busy) begin
        unique case (op)
          OP_MUL: begin
            if (opb_r[0]) acc <= acc + work;
            work  <= {work[WIDE_BITS-2:0], 1'b0};
            opb_r <= {1'b0, opb_r[MULB_BITS-1:1]};
          end
          OP_DIV: begin
            if (trial >= {1'b0, opb_r}) begin
              rem  <= diff[MULB_BITS-1:0];
              work <= {work[WIDE_BITS-2:0], 1'b1};
            end else begin
              rem  <= trial[MULB_BITS-1:0];
              work <= {work[WIDE_BITS-2:0], 1'b0};
            end
          end
          default: ;
        endcase
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign result     = (op == OP_MUL) ? acc : work;
  assign rsp.done   = done;
  assign rsp.rem_nz = (rem != '0);

endmodule

// ===== rtl/trend_breakout_signal.sv =====
// Top level of the trend breakout signal: history ring, scan and entry sequencer.
// Sequence: a history scan of max(fast, slow, range+1, breakout+1) entries,
// then up to seven multiplies and two divides (on an entry), then a finish step.
// One item at a time: a new item is accepted only after the last result is emitted.
// Reset: registers take their defaults, history fill and sums clear, cooldown 1048576.
// History memory needs no clearing pass; fill is not checked against the fast length.
`include "trend_breakout_signal_assert.svh"

module trend_breakout_signal (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [tbs_pkg::PRICE_BITS-1:0]   price,
  input  logic [tbs_pkg::TIME_BITS-1:0]    timestamp,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       signal,
  output logic [tbs_pkg::PRICE_BITS-1:0]   entry_price,
  output logic [tbs_pkg::PRICE_BITS-1:0]   stop_price,
  output logic [tbs_pkg::PRICE_BITS-1:0]   target_price,
  output logic [tbs_pkg::TIME_BITS-1:0]    emit_time,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [2:0]                       cfg_index,
  input  logic [15:0]                      cfg_data
);
  import tbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_SCAN, ST_ARITH, ST_V1, ST_V2, ST_V3, ST_V4,
    ST_T1, ST_T2, ST_X1, ST_X2, ST_X3, ST_X4, ST_FIN, ST_EMIT
  } state_t;

  state_t state, ret_state;

  // Configuration registers.
  logic [7:0]  fast_len, slow_len, brk_len, rng_len;
  logic [15:0] stop_mul, reward_mul, cool_len;
  logic [13:0] min_vol;

  // Per-item state.
  logic [HIST_AW-1:0]    head;
  logic [HIST_AW:0]      fill;
  logic [SINCE_BITS-1:0] since;
  logic [PRICE_BITS-1:0] mark;
  logic [TIME_BITS-1:0]  ts;

  // Scan state.
  logic [HIST_AW:0]      cnt;
  logic [HIST_AW:0]      scan_count;
  logic [HIST_AW:0]      need_plus;
  logic [HIST_AW-1:0]    rd_addr;
  logic                  rd_valid;
  logic [HIST_AW:0]      rd_k;
  logic [PRICE_BITS-1:0] rd_data;
  logic [PRICE_BITS-1:0] prev;
  logic [PRICE_BITS-1:0] abs_diff;
  logic [SUM_BITS-1:0]   fast_sum, slow_sum, chg_sum;
  logic [PRICE_BITS-1:0] hi;
  logic [PRICE_BITS:0]   lo;
  logic [PRICE_BITS-1:0] hist [HISTORY_DEPTH];

  // Arithmetic results.
  logic [WIDE_BITS-1:0]  a_reg, p_reg, d_q;
  logic                  d_rz;
  logic [1:0]            sig_r;
  logic [PRICE_BITS-1:0] stop_r, tgt_r;

  // Shared unit interface.
  arith_req_t            a_req;
  arith_rsp_t            a_rsp;
  logic [WIDE_BITS-1:0]  a_opa, a_res;
  logic [MULB_BITS-1:0]  a_opb;

  logic [PRICE_BITS-1:0] mark1;
  logic                  vol_low, cool_block, long_hit, short_hit;
  logic [PRICE_BITS+1:0] d_fl, d_ce, t_fl, t_ce;
  logic [7:0]            need8;

  tbs_arith u_arith (
    .clk    (clk),
    .rst    (rst),
    .req    (a_req),
    .opa    (a_opa),
    .opb    (a_opb),
    .rsp    (a_rsp),
    .result (a_res)
  );

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // History need and scan length.
  always_comb begin
    need8 = slow_len;
    if (brk_len > need8) need8 = brk_len;
    if (rng_len > need8) need8 = rng_len;
    need_plus  = (HIST_AW+1)'(need8) + 1'b1;
    scan_count = (HIST_AW+1)'(fast_len);
    if ((HIST_AW+1)'(slow_len) > scan_count) scan_count = (HIST_AW+1)'(slow_len);
    if ((HIST_AW+1)'(rng_len) + 1'b1 > scan_count) scan_count = (HIST_AW+1)'(rng_len) + 1'b1;
    if ((HIST_AW+1)'(brk_len) + 1'b1 > scan_count) scan_count = (HIST_AW+1)'(brk_len) + 1'b1;
  end

  assign rd_addr  = head - 1'b1 - cnt[HIST_AW-1:0];
  assign abs_diff = (prev > rd_data) ? (prev - rd_data) : (rd_data - prev);
  assign mark1    = (mark == '0) ? PRICE_BITS'(1) : mark;

  // Entry decisions from the latest products.
  assign vol_low    = (rng_len == '0) ? (min_vol != '0) : (a_reg < a_res);
  assign cool_block = (since < SINCE_BITS'(cool_len));
  assign long_hit   = (a_reg > a_res) && ({1'b0, mark} > {1'b0, hi});
  assign short_hit  = (a_reg < a_res) && ({1'b0, mark} < lo);

  // Exit distances, floor and ceiling.
  assign d_fl = clamp_q(d_q);
  assign d_ce = d_fl + (PRICE_BITS+2)'(d_rz);
  assign t_fl = clamp_q(a_res);
  assign t_ce = t_fl + (PRICE_BITS+2)'(a_rsp.rem_nz);

  // History memory with registered read.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hist[head] <= price;
    rd_data <= hist[rd_addr];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_len   <= 8'd50;
      slow_len   <= 8'd200;
      brk_len    <= 8'd100;
      rng_len    <= 8'd100;
      stop_mul   <= 16'd200;
      reward_mul <= 16'd150;
      min_vol    <= 14'd8;
      cool_len   <= 16'd30;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FAST:     fast_len   <= cfg_data[7:0];
        REG_SLOW:     slow_len   <= cfg_data[7:0];
        REG_BREAKOUT: brk_len    <= cfg_data[7:0];
        REG_RANGE:    rng_len    <= cfg_data[7:0];
        REG_STOP:     stop_mul   <= cfg_data;
        REG_REWARD:   reward_mul <= cfg_data;
        REG_MINVOL:   min_vol    <= cfg_data[13:0];
        REG_COOL:     cool_len   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, scan accumulators and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
      head      <= '0;
      fill      <= '0;
      since     <= SINCE_RESET;
      rd_valid  <= 1'b0;
      a_req     <= '0;
      out_valid <= 1'b0;
      fast_sum  <= '0;
      slow_sum  <= '0;
      chg_sum   <= '0;
    end else begin
      // The emit state reloads the result register itself.
      if (out_valid && out_ready && (state != ST_EMIT)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mark <= price;
            ts   <= timestamp;
            head <= head + 1'b1;
            if (fill < (HIST_AW+1)'(HISTORY_DEPTH)) fill <= fill + 1'b1;
            if (since < SINCE_MAX) since <= since + 1'b1;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          sig_r <= SIG_NONE;
          if (fill < need_plus) begin
            state <= ST_EMIT;
          end else begin
            cnt      <= '0;
            rd_valid <= 1'b0;
            fast_sum <= '0;
            slow_sum <= '0;
            chg_sum  <= '0;
            hi       <= '0;
            lo       <= '1;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle and fold in the one returned.
          rd_valid <= (cnt < scan_count);
          rd_k     <= cnt;
          if (cnt < scan_count) cnt <= cnt + 1'b1;
          if (rd_valid) begin
            prev <= rd_data;
            if (rd_k < (HIST_AW+1)'(fast_len))
              fast_sum <= fast_sum + SUM_BITS'(rd_data);
            if (rd_k < (HIST_AW+1)'(slow_len))
              slow_sum <= slow_sum + SUM_BITS'(rd_data);
            if ((rd_k != '0) && (rd_k <= (HIST_AW+1)'(rng_len)))
              chg_sum <= chg_sum + SUM_BITS'(abs_diff);
            if ((rd_k != '0) && (rd_k <= (HIST_AW+1)'(brk_len))) begin
              if (rd_data > hi) hi <= rd_data;
              if ({1'b0, rd_data} < lo) lo <= {1'b0, rd_data};
            end
          end
          if (cnt == scan_count) state <= ST_V1;
        end
        ST_ARITH: begin
          // The start pulse lasts one cycle.
          a_req.start <= 1'b0;
          if (a_rsp.done) state <= ret_state;
        end
        ST_V1: begin
          a_req     <= '{start: 1'b1, op: OP_MUL};
          a_opa     <= WIDE_BITS'(chg_sum);
          a_opb     <= MULB_BITS'(10000);
          ret_state <= ST_V2;
          state     <= ST_ARITH;
        end
        ST_V2: begin
          a_reg     <= a_res;
          a_req     <= '{start: 1'b1, op: OP_MUL};
          a_opa     <= WIDE_BITS'(min_vol);
          a_opb     <= MULB_BITS'(rng_len);
          ret_state <= ST_V3;
          state     <= ST_ARITH;
        end
        ST_V3: begin
          a_req     <= '{start: 1'b1, op: OP_MUL};
          a_opa     <= WIDE_BITS'(mark1);
          a_opb     <= a_res[MULB_BITS-1:0];
          ret_state <= ST_V4;
          state     <= ST_ARITH;
        end
        ST_V4: begin
          if (vol_low || cool_block) begin
            state <= ST_EMIT;
          end else begin
            a_req     <= '{start: 1'b1, op: OP_MUL};
            a_opa     <= WIDE_BITS'(fast_sum);
            a_opb     <= MULB_BITS'(slow_len);
            ret_state <= ST_T1;
            state     <= ST_ARITH;
          end
        end
        ST_T1: begin
          a_reg     <= a_res;
          a_req     <= '{start: 1'b1, op: OP_MUL};
          a_opa     <= WIDE_BITS'(slow_sum);
          a_opb     <= MULB_BITS'(fast_len);
          ret_state <= ST_T2;
          state     <= ST_ARITH;
        end
        ST_T2: begin
          if (!long_hit && !short_hit) begin
            state <= ST_EMIT;
          end else begin
            since <= '0;
            sig_r <= long_hit ? SIG_LONG : SIG_SHORT;
            if (rng_len == '0) begin
              // No range: both distances are zero.
              d_q   <= '0;
              d_rz  <= 1'b0;
              state <= ST_FIN;
            end else begin
              a_req     <= '{start: 1'b1, op: OP_MUL};
              a_opa     <= WIDE_BITS'(chg_sum);
              a_opb     <= MULB_BITS'(stop_mul);
              ret_state <= ST_X1;
              state     <= ST_ARITH;
            end
          end
        end
        ST_X1: begin
          p_reg     <= a_res;
          a_req     <= '{start: 1'b1, op: OP_DIV};
          a_opa     <= a_res;
          a_opb     <= MULB_BITS'(rng_len) * MULB_BITS'(100);
          ret_state <= ST_X2;
          state     <= ST_ARITH;
        end
        ST_X2: begin
          d_q       <= a_res;
          d_rz      <= a_rsp.rem_nz;
          a_req     <= '{start: 1'b1, op: OP_MUL};
          a_opa     <= p_reg;
          a_opb     <= MULB_BITS'(reward_mul);
          ret_state <= ST_X3;
          state     <= ST_ARITH;
        end
        ST_X3: begin
          a_req     <= '{start: 1'b1, op: OP_DIV};
          a_opa     <= a_res;
          a_opb     <= MULB_BITS'(rng_len) * MULB_BITS'(10000);
          ret_state <= ST_X4;
          state     <= ST_ARITH;
        end
        ST_X4: begin
          // Target quotient stays on the unit's result port.
          if (sig_r == SIG_LONG) begin
            stop_r <= sub_floor1(mark, d_ce);
            tgt_r  <= add_sat(mark, t_fl);
          end else begin
            stop_r <= add_sat(mark, d_fl);
            tgt_r  <= sub_floor1(mark, t_ce);
          end
          state <= ST_EMIT;
        end
        ST_FIN: begin
          // Zero distances with zero range.
          if (sig_r == SIG_LONG) begin
            stop_r <= sub_floor1(mark, '0);
            tgt_r  <= add_sat(mark, '0);
          end else begin
            stop_r <= add_sat(mark, '0);
            tgt_r  <= sub_floor1(mark, '0);
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            signal       <= sig_r;
            entry_price  <= (sig_r != SIG_NONE) ? mark : '0;
            stop_price   <= (sig_r != SIG_NONE) ? stop_r : '0;
            target_price <= (sig_r != SIG_NONE) ? tgt_r : '0;
            emit_time    <= (sig_r != SIG_NONE) ? ts : '0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks on the sequencer and the result contents.
  `TBS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `TBS_ASSERT_IMP(a_entry_prices, out_valid && (signal != SIG_NONE), |stop_price && |target_price)
  `TBS_ASSERT_IMP(a_none_zero, out_valid && (signal == SIG_NONE), (entry_price == '0) && (emit_time == '0))

endmodule
